@@ sv/chpp_pkg.sv @@
// ----------------------------------------------------------------------------
// chpp_pkg: shared types, constants and byte classes for the cookie parser.
// Holds the character constants, the field widths and the class record that
// travels from the front end to the back end.
// ----------------------------------------------------------------------------
package chpp_pkg;

  localparam int unsigned FIELD_W = 12;

  localparam logic [7:0] CH_EQ    = 8'h3D;  // '='
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [7:0] CH_TAB   = 8'h09;  // '\t'
  localparam logic [7:0] CH_QUOTE = 8'h22;  // '"'

  // Classes of one header byte plus the end-of-header mark.
  typedef struct packed {
    logic sp;      // space or tab
    logic token;   // token character of a name
    logic octet;   // bare cookie-octet
    logic qoctet;  // cookie-octet or space inside quotes
    logic eq;
    logic semi;
    logic quote;
    logic last;
  } chpp_class_t;

  function automatic logic is_token(input logic [7:0] c);
    logic sep;
    sep = (c == 8'h22) || (c == 8'h28) || (c == 8'h29) || (c == 8'h2C) ||
          (c == 8'h2F) || (c == 8'h3A) || (c == 8'h3B) || (c == 8'h3C) ||
          (c == 8'h3D) || (c == 8'h3E) || (c == 8'h3F) || (c == 8'h40) ||
          (c == 8'h5B) || (c == 8'h5C) || (c == 8'h5D) || (c == 8'h7B) ||
          (c == 8'h7D);
    return (c >= 8'd33) && (c <= 8'd126) && !sep;
  endfunction

  function automatic logic is_octet(input logic [7:0] c);
    return (c >= 8'h21) && (c <= 8'h7E) && (c != CH_QUOTE) && (c != 8'h2C) &&
           (c != CH_SEMI) && (c != 8'h5C);
  endfunction

  function automatic chpp_class_t classify(input logic [7:0] c, input logic last);
    chpp_class_t k;
    k.sp     = (c == CH_SPACE) || (c == CH_TAB);
    k.token  = is_token(c);
    k.octet  = is_octet(c);
    k.qoctet = (c == CH_SPACE) || is_octet(c);
    k.eq     = (c == CH_EQ);
    k.semi   = (c == CH_SEMI);
    k.quote  = (c == CH_QUOTE);
    k.last   = last;
    return k;
  endfunction

endpackage

@@ sv/chpp_front.sv @@
// ----------------------------------------------------------------------------
// chpp_front: input side of the cookie parser.
// Classifies each accepted byte and holds it in a two-entry queue for the
// back end.
// ----------------------------------------------------------------------------
module chpp_front
  import chpp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  header_byte,
  input  logic        last_byte,
  output logic        q_valid,
  output chpp_class_t q_class,
  input  logic        q_pop
);

  chpp_class_t entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        push;

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_class  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= classify(header_byte, last_byte);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (count == 2'd2) && !q_pop |=> (count == 2'd2))
    else $error("full queue lost an entry without a pop");

endmodule

@@ sv/chpp_back.sv @@
// ----------------------------------------------------------------------------
// chpp_back: parsing engine of the cookie parser.
// Runs the pair state machine on classified bytes and holds each result in
// an output register until the receiver takes it.
// ----------------------------------------------------------------------------
module chpp_back
  import chpp_pkg::*;
#(
  parameter int unsigned MAX_HEADER_LEN = 4096,
  parameter int unsigned POS_W          = 13
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  chpp_class_t         q_class,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                status,
  output logic [FIELD_W-1:0]  name_start,
  output logic [FIELD_W-1:0]  name_length,
  output logic [FIELD_W-1:0]  value_start,
  output logic [FIELD_W-1:0]  value_length,
  output logic                value_quoted,
  output logic                header_end
);

  typedef enum logic [2:0] {
    PH_LEAD, PH_NAME, PH_NAME_SP, PH_AFTER_EQ, PH_BARE, PH_QUOTED, PH_END_SP, PH_SKIP
  } phase_t;

  phase_t             phase, phase_next;
  logic [POS_W-1:0]   pos, pos_next, pos_inc;
  logic [FIELD_W-1:0] name_offset, name_offset_next;
  logic [FIELD_W-1:0] name_count, name_count_next;
  logic [FIELD_W-1:0] value_offset, value_offset_next;
  logic [FIELD_W-1:0] value_count, value_count_next;
  logic               quoted_flag, quoted_flag_next;
  logic               err, pair, emit;
  logic [FIELD_W-1:0] r_name_start, r_name_length, r_value_start, r_value_length;
  logic               r_quoted;

  assign q_pop   = q_valid && (!out_valid || !out_stall);
  assign pos_inc = pos + POS_W'(1);

  always_comb begin
    phase_next        = phase;
    pos_next          = pos;
    name_offset_next  = name_offset;
    name_count_next   = name_count;
    value_offset_next = value_offset;
    value_count_next  = value_count;
    quoted_flag_next  = quoted_flag;
    err               = 1'b0;
    pair              = 1'b0;

    if (phase != PH_SKIP) begin
      if (pos >= POS_W'(MAX_HEADER_LEN)) begin
        err = 1'b1;
      end else begin
        pos_next = pos_inc;
        unique case (phase)
          PH_LEAD: begin
            if (q_class.sp) begin
              phase_next = PH_LEAD;
            end else if (q_class.token) begin
              name_offset_next  = FIELD_W'(pos);
              name_count_next   = FIELD_W'(1);
              value_offset_next = '0;
              value_count_next  = '0;
              quoted_flag_next  = 1'b0;
              phase_next        = PH_NAME;
            end else begin
              err = 1'b1;
            end
          end
          PH_NAME, PH_NAME_SP: begin
            if (phase == PH_NAME && q_class.token) begin
              name_count_next = name_count + FIELD_W'(1);
            end else if (q_class.sp) begin
              phase_next = PH_NAME_SP;
            end else if (q_class.eq) begin
              value_offset_next = FIELD_W'(pos_inc);
              value_count_next  = '0;
              quoted_flag_next  = 1'b0;
              phase_next        = PH_AFTER_EQ;
            end else begin
              err = 1'b1;
            end
          end
          PH_AFTER_EQ: begin
            if (q_class.sp) begin
              value_offset_next = FIELD_W'(pos_inc);
            end else if (q_class.quote) begin
              value_offset_next = FIELD_W'(pos_inc);
              value_count_next  = '0;
              quoted_flag_next  = 1'b1;
              phase_next        = PH_QUOTED;
            end else if (q_class.octet) begin
              value_offset_next = FIELD_W'(pos);
              value_count_next  = FIELD_W'(1);
              phase_next        = PH_BARE;
            end else if (q_class.semi) begin
              pair = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
          PH_BARE: begin
            if (q_class.octet) begin
              value_count_next = value_count + FIELD_W'(1);
            end else if (q_class.sp) begin
              phase_next = PH_END_SP;
            end else if (q_class.semi) begin
              pair = 1'b1;
            end else begin
              err = 1'b1;
            end
          end
          PH_QUOTED: begin
            if (q_class.qoctet) begin
              value_count_next = value_count + FIELD_W'(1);
            end else if (q_class.quote) begin
              phase_next = PH_END_SP;
            end else begin
              err = 1'b1;
            end
          end
          PH_END_SP: begin
            if (q_class.semi) begin
              pair = 1'b1;
            end else if (!q_class.sp) begin
              err = 1'b1;
            end
          end
          default: begin
            err = 1'b1;
          end
        endcase
      end

      // End of header decides between a finished pair and a truncated one.
      if (!err && !pair && q_class.last) begin
        if (phase_next == PH_AFTER_EQ || phase_next == PH_BARE ||
            phase_next == PH_END_SP) begin
          pair = 1'b1;
        end else begin
          err = 1'b1;
        end
      end
    end

    emit           = err || pair;
    r_name_start   = err ? '0 : name_offset_next;
    r_name_length  = err ? '0 : name_count_next;
    r_value_start  = err ? '0 : value_offset_next;
    r_value_length = err ? '0 : value_count_next;
    r_quoted       = err ? 1'b0 : quoted_flag_next;

    if (err && !q_class.last) begin
      phase_next = PH_SKIP;
    end else if (pair && !q_class.last) begin
      phase_next = PH_LEAD;
    end

    if (q_class.last) begin
      phase_next        = PH_LEAD;
      pos_next          = '0;
      name_offset_next  = '0;
      name_count_next   = '0;
      value_offset_next = '0;
      value_count_next  = '0;
      quoted_flag_next  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_LEAD;
      pos          <= '0;
      name_offset  <= '0;
      name_count   <= '0;
      value_offset <= '0;
      value_count  <= '0;
      quoted_flag  <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (q_pop) begin
        phase        <= phase_next;
        pos          <= pos_next;
        name_offset  <= name_offset_next;
        name_count   <= name_count_next;
        value_offset <= value_offset_next;
        value_count  <= value_count_next;
        quoted_flag  <= quoted_flag_next;
      end
      if (q_pop && emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      status       <= err;
      name_start   <= r_name_start;
      name_length  <= r_name_length;
      value_start  <= r_value_start;
      value_length <= r_value_length;
      value_quoted <= r_quoted;
      header_end   <= err || q_class.last;
    end
  end

  a_err_ends_header: assert property (@(posedge clk) disable iff (rst)
    q_pop && err |=> out_valid && status && header_end)
    else $error("error result does not close the header");

  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> name_start == '0 && name_length == '0 &&
    value_start == '0 && value_length == '0 && !value_quoted)
    else $error("error result carries nonzero fields");

  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    q_pop && q_class.last |=> phase == PH_LEAD && pos == '0)
    else $error("state not cleared after final byte");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    pos <= POS_W'(MAX_HEADER_LEN))
    else $error("byte position beyond header limit");

endmodule

@@ sv/cookie_header_pair_parser_core.sv @@
// ----------------------------------------------------------------------------
// cookie_header_pair_parser_core: Cookie header name=value pair parser.
// Streams header bytes in and reports each pair as offsets and lengths.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one request per header byte, with
// last_byte set on the final byte of a header. The output channel carries
// one request per finished pair (status 0) or one error request (status 1)
// on the first malformed byte, after which the rest of that header gives
// nothing. header_end marks the final request of a header.
// Throughput is one byte per cycle while the receiver does not stall: the
// state machine makes one phase transition per byte, fed from a table-like
// byte classifier. A byte is classified into a two-entry queue when it is
// accepted, the parser takes it from the queue once the output register is
// free, and its result is registered in the output register.
// When the receiver stalls, the result is held, the parser stops taking
// bytes for as long as a result waits in the output register, and the queue
// fills; in_stall rises when the queue holds two bytes. Reset empties the
// queue and the output register and returns the parser to the start of a
// header.
// ----------------------------------------------------------------------------
module cookie_header_pair_parser_core
  import chpp_pkg::*;
#(
  parameter int unsigned MAX_HEADER_LEN = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         header_byte,
  input  logic               last_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic [FIELD_W-1:0] name_start,
  output logic [FIELD_W-1:0] name_length,
  output logic [FIELD_W-1:0] value_start,
  output logic [FIELD_W-1:0] value_length,
  output logic               value_quoted,
  output logic               header_end
);

  // The position must hold the limit itself, which flags an overlong header.
  localparam int unsigned POS_W = $clog2(MAX_HEADER_LEN + 1);

  logic        q_valid;
  logic        q_pop;
  chpp_class_t q_class;

  // Front end: classifies bytes and buffers them so that input acceptance
  // waits on the output side only once the queue is full.
  chpp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .header_byte (header_byte),
    .last_byte   (last_byte),
    .q_valid     (q_valid),
    .q_class     (q_class),
    .q_pop       (q_pop)
  );

  // Back end: the pair state machine and the output register.
  chpp_back #(
    .MAX_HEADER_LEN (MAX_HEADER_LEN),
    .POS_W          (POS_W)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_class      (q_class),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .name_start   (name_start),
    .name_length  (name_length),
    .value_start  (value_start),
    .value_length (value_length),
    .value_quoted (value_quoted),
    .header_end   (header_end)
  );

endmodule

@@ verif/cookie_pair_checker.sv @@
// ----------------------------------------------------------------------------
// cookie_pair_checker: result predictor and scoreboard for the Cookie parser
// Watches both channels of the parser core. It runs its own model of the
// pair parser on every accepted header byte and compares every accepted
// result request, field by field, with the oldest predicted one.
// ----------------------------------------------------------------------------
module cookie_pair_checker
  import chpp_pkg::*;
#(
  parameter int unsigned MAX_HEADER_LEN = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic [7:0]         header_byte,
  input  logic               last_byte,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic               status,
  input  logic [FIELD_W-1:0] name_start,
  input  logic [FIELD_W-1:0] name_length,
  input  logic [FIELD_W-1:0] value_start,
  input  logic [FIELD_W-1:0] value_length,
  input  logic               value_quoted,
  input  logic               header_end,
  output int unsigned        fail_count,
  output int unsigned        pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic STATUS_PAIR      = 1'b0;
  localparam logic STATUS_MALFORMED = 1'b1;

  typedef enum logic [3:0] {
    PARSE_LEAD,
    PARSE_NAME,
    PARSE_NAME_SP,
    PARSE_AFTER_EQ,
    PARSE_BARE,
    PARSE_QUOTED,
    PARSE_END_SP,
    PARSE_SKIP
  } parse_phase_t;

  typedef struct packed {
    logic               status;
    logic [FIELD_W-1:0] name_start;
    logic [FIELD_W-1:0] name_length;
    logic [FIELD_W-1:0] value_start;
    logic [FIELD_W-1:0] value_length;
    logic               value_quoted;
    logic               header_end;
  } cookie_pair_t;

  cookie_pair_t expected_pairs[$];

  parse_phase_t phase;
  int unsigned  hdr_pos;
  int unsigned  name_off;
  int unsigned  name_cnt;
  int unsigned  val_off;
  int unsigned  val_cnt;
  logic         in_quotes;

  function automatic logic blank_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  // Token characters: visible ASCII without the separator set.
  function automatic logic token_char(input logic [7:0] c);
    if (c < 8'd33 || c > 8'd126) return 1'b0;
    case (c)
      "\"", "(", ")", ",", "/", ":", ";", "<", "=", ">", "?", "@", "[", "\\",
      "]", "{", "}": return 1'b0;
      default: return 1'b1;
    endcase
  endfunction

  function automatic logic bare_char(input logic [7:0] c);
    if (c < 8'h21 || c > 8'h7E) return 1'b0;
    return !(c == "\"" || c == "," || c == ";" || c == "\\");
  endfunction

  function automatic void restart_header();
    phase     = PARSE_LEAD;
    hdr_pos   = 0;
    name_off  = 0;
    name_cnt  = 0;
    val_off   = 0;
    val_cnt   = 0;
    in_quotes = 1'b0;
  endfunction

  // Advances the parse by one header byte and queues the result it causes.
  function automatic void predict_byte(input logic [7:0] c, input logic last);
    logic         bad;
    logic         done;
    int unsigned  pos;
    cookie_pair_t r;
    bad  = 1'b0;
    done = 1'b0;
    pos  = hdr_pos;
    if (phase == PARSE_SKIP) begin
      if (last) restart_header();
      return;
    end
    if (pos >= MAX_HEADER_LEN) begin
      bad = 1'b1;
    end else begin
      case (phase)
        PARSE_LEAD: begin
          if (token_char(c)) begin
            name_off  = pos;
            name_cnt  = 1;
            val_off   = 0;
            val_cnt   = 0;
            in_quotes = 1'b0;
            phase     = PARSE_NAME;
          end else if (!blank_char(c)) begin
            bad = 1'b1;
          end
        end
        PARSE_NAME, PARSE_NAME_SP: begin
          if (phase == PARSE_NAME && token_char(c)) name_cnt++;
          else if (blank_char(c)) phase = PARSE_NAME_SP;
          else if (c == CH_EQ) begin
            val_off   = pos + 1;
            val_cnt   = 0;
            in_quotes = 1'b0;
            phase     = PARSE_AFTER_EQ;
          end else bad = 1'b1;
        end
        PARSE_AFTER_EQ: begin
          if (blank_char(c)) val_off = pos + 1;
          else if (c == CH_QUOTE) begin
            val_off   = pos + 1;
            val_cnt   = 0;
            in_quotes = 1'b1;
            phase     = PARSE_QUOTED;
          end else if (bare_char(c)) begin
            val_off = pos;
            val_cnt = 1;
            phase   = PARSE_BARE;
          end else if (c == CH_SEMI) done = 1'b1;
          else bad = 1'b1;
        end
        PARSE_BARE: begin
          if (bare_char(c)) val_cnt++;
          else if (blank_char(c)) phase = PARSE_END_SP;
          else if (c == CH_SEMI) done = 1'b1;
          else bad = 1'b1;
        end
        PARSE_QUOTED: begin
          if (c == CH_SPACE || bare_char(c)) val_cnt++;
          else if (c == CH_QUOTE) phase = PARSE_END_SP;
          else bad = 1'b1;
        end
        PARSE_END_SP: begin
          if (c == CH_SEMI) done = 1'b1;
          else if (!blank_char(c)) bad = 1'b1;
        end
        default: bad = 1'b1;
      endcase
      hdr_pos = pos + 1;
    end

    // The end of the header closes a pair only where a value may stop.
    if (!bad && !done && last) begin
      if (phase == PARSE_AFTER_EQ || phase == PARSE_BARE || phase == PARSE_END_SP)
        done = 1'b1;
      else
        bad = 1'b1;
    end

    if (bad) begin
      r = '0;
      r.status     = STATUS_MALFORMED;
      r.header_end = 1'b1;
      expected_pairs.push_back(r);
      if (last) restart_header();
      else phase = PARSE_SKIP;
    end else if (done) begin
      r.status       = STATUS_PAIR;
      r.name_start   = name_off[FIELD_W-1:0];
      r.name_length  = name_cnt[FIELD_W-1:0];
      r.value_start  = val_off[FIELD_W-1:0];
      r.value_length = val_cnt[FIELD_W-1:0];
      r.value_quoted = in_quotes;
      r.header_end   = last;
      expected_pairs.push_back(r);
      if (last) restart_header();
      else phase = PARSE_LEAD;
    end
  endfunction

  function automatic void compare_field(input string fname, input int unsigned want,
                                        input int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      fail_count++;
    end
  endfunction

  always @(posedge clk) begin
    cookie_pair_t want;
    if (rst) begin
      restart_header();
      expected_pairs.delete();
      fail_count = 0;
    end else begin
      if (in_valid && !in_stall) predict_byte(header_byte, last_byte);
      if (out_valid && !out_stall) begin
        if (expected_pairs.size() == 0) begin
          $error("result request with nothing expected (status %0d)", status);
          fail_count++;
        end else begin
          want = expected_pairs.pop_front();
          compare_field("status", want.status, status);
          compare_field("name_start", want.name_start, name_start);
          compare_field("name_length", want.name_length, name_length);
          compare_field("value_start", want.value_start, value_start);
          compare_field("value_length", want.value_length, value_length);
          compare_field("value_quoted", want.value_quoted, value_quoted);
          compare_field("header_end", want.header_end, header_end);
        end
      end
    end
    pending_count = expected_pairs.size();
  end

endmodule

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench top for cookie_header_pair_parser_core
// Feeds Cookie headers byte by byte, first a few hand-made ones, then
// random headers under three idling patterns. The checker beside the core
// predicts and compares results; this module only makes the stimulus and
// gives the verdict.
// ----------------------------------------------------------------------------
module tb
  import chpp_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HDR_LIMIT = 4096;

  typedef logic [7:0] hdr_bytes_t[$];

  logic               clk;
  logic               rst          = 1'b1;
  logic               in_valid     = 1'b0;
  logic               in_stall;
  logic [7:0]         header_byte  = '0;
  logic               last_byte    = 1'b0;
  logic               out_valid;
  logic               out_stall    = 1'b0;
  logic               status;
  logic [FIELD_W-1:0] name_start;
  logic [FIELD_W-1:0] name_length;
  logic [FIELD_W-1:0] value_start;
  logic [FIELD_W-1:0] value_length;
  logic               value_quoted;
  logic               header_end;
  int unsigned        fail_count;
  int unsigned        pending_count;

  // Percent chance, per cycle, that the sender holds back a request and
  // that the receiver stalls a result request.
  int unsigned        gap_pct      = 0;
  int unsigned        stall_pct    = 0;

  cookie_header_pair_parser_core #(.MAX_HEADER_LEN(HDR_LIMIT)) dut (.*);

  cookie_pair_checker #(.MAX_HEADER_LEN(HDR_LIMIT)) u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // The receiver stalls at random. Its stall never looks at out_valid.
  always @(posedge clk) begin
    if (rst) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sends one byte request. Random gaps come first. All drives happen at the
  // rising edge; in_stall is sampled at the falling edge, where it already
  // holds the value that the next rising edge will see, since every input
  // of the core changes only at rising edges.
  task automatic put_byte(input logic [7:0] b, input logic l);
    logic taken;
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    header_byte <= b;
    last_byte   <= l;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
  endtask

  task automatic send_header(input hdr_bytes_t h);
    foreach (h[i]) put_byte(h[i], i == h.size() - 1);
  endtask

  task automatic send_text(input string s);
    hdr_bytes_t h;
    for (int i = 0; i < s.len(); i++) h.push_back(s[i]);
    send_header(h);
  endtask

  function automatic logic [7:0] pick_token();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!is_token(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_octet();
    logic [7:0] c;
    do c = 8'($urandom_range(33, 126)); while (!is_octet(c));
    return c;
  endfunction

  function automatic logic [7:0] pick_blank();
    return $urandom_range(1) ? CH_SPACE : CH_TAB;
  endfunction

  // Builds a well-formed header of one to four pairs with random spacing and
  // value forms, then now and then breaks it: a byte is overwritten with any
  // value, the header is cut short, or a stray space follows a final ';'.
  // About one header in ten is pure noise.
  function automatic hdr_bytes_t make_header();
    hdr_bytes_t h;
    int unsigned n_pairs;
    int unsigned cut;
    if ($urandom_range(9) == 0) begin
      repeat ($urandom_range(1, 8)) h.push_back(8'($urandom_range(255)));
      return h;
    end
    n_pairs = $urandom_range(1, 4);
    repeat ($urandom_range(0, 2)) h.push_back(pick_blank());
    for (int p = 0; p < n_pairs; p++) begin
      if (p > 0) begin
        h.push_back(CH_SEMI);
        repeat ($urandom_range(0, 2)) h.push_back(pick_blank());
      end
      repeat ($urandom_range(1, 6)) h.push_back(pick_token());
      repeat ($urandom_range(0, 1)) h.push_back(pick_blank());
      h.push_back(CH_EQ);
      repeat ($urandom_range(0, 1)) h.push_back(pick_blank());
      case ($urandom_range(2))
        0: repeat ($urandom_range(1, 6)) h.push_back(pick_octet());
        1: begin
          h.push_back(CH_QUOTE);
          repeat ($urandom_range(0, 6))
            h.push_back($urandom_range(3) == 0 ? CH_SPACE : pick_octet());
          h.push_back(CH_QUOTE);
        end
        default: ;
      endcase
      repeat ($urandom_range(0, 1)) h.push_back(pick_blank());
    end
    if ($urandom_range(4) == 0) h.push_back(CH_SEMI);
    case ($urandom_range(9))
      0, 1: h[$urandom_range(h.size() - 1)] = 8'($urandom_range(255));
      2: begin
        cut = $urandom_range(1, h.size());
        while (h.size() > cut) void'(h.pop_back());
      end
      3: begin
        h.push_back(CH_SEMI);
        h.push_back(CH_SPACE);
      end
      default: ;
    endcase
    return h;
  endfunction

  initial begin
    hdr_bytes_t  h;
    int unsigned sent;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed headers, under the first idling pattern.
    gap_pct   = 18;
    stall_pct = 60;
    // A pair closed by ';' on the final byte still ends the header.
    send_text("a=1;");
    // Leading space, tab before '=', space after '=', quoted value holding
    // a space, space before ';', and an empty value at the end.
    send_text(" b\t= \"q r\" ;c=");
    // A name with no '=' is malformed; the byte after it is ignored.
    send_text("d;x");
    // The header ends inside a quoted value.
    send_text("f=\"g");
    // A space after the last ';' where a name should be.
    send_text("x=1; ");
    // A space inside a bare value, then more value bytes.
    send_text("k=v v");
    // The byte extremes: a lone zero byte, and 0xFF as a value.
    h = {8'h00};
    send_header(h);
    h = {8'h65, CH_EQ, 8'hFF};
    send_header(h);

    // Random headers: sender idles lightly and the receiver heavily, then
    // the other way round, then neither idles.
    for (int round = 0; round < 3; round++) begin
      gap_pct   = (round == 0) ? 18 : (round == 1) ? 60 : 0;
      stall_pct = (round == 0) ? 60 : (round == 1) ? 18 : 0;
      sent = 0;
      while (sent < 250) begin
        h = make_header();
        send_header(h);
        sent += h.size();
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every predicted result, then keep waiting so that
    // any extra result request would still be caught.
    do @(negedge clk); while (pending_count != 0);
    repeat (8) @(negedge clk);
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: the slowest correct run takes well under a tenth of this.
  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
